// ===== rtl/core/sphere_pair_elastic_collision_unit_macros.svh =====
// Assertion macros used by the checker file of the collision unit
`ifndef SPHERE_PAIR_ELASTIC_COLLISION_UNIT_MACROS_SVH
`define SPHERE_PAIR_ELASTIC_COLLISION_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SPEC_ASSERT_NOW(lbl, clk, rst, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error("spec check failed");

// Next-cycle implication, disabled during reset
`define SPEC_ASSERT_NEXT(lbl, clk, rst, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error("spec check failed");

`endif

// ===== rtl/core/spec_pkg.sv =====
// Shared types and constants of the sphere pair collision unit
package spec_pkg;

  localparam int CW_DEFAULT = 16;

  // Contact test selection
  localparam logic MODE_BOX      = 1'b0;
  localparam logic MODE_DISTANCE = 1'b1;
  localparam logic CONTACT_MODE_RESET = MODE_DISTANCE;

  // Register index as decoded from paddr[2]
  localparam logic REG_CONTACT_MODE = 1'b0;

  typedef enum logic [1:0] {
    OUT_NONE       = 2'd0,
    OUT_SEPARATING = 2'd1,
    OUT_COLLIDED   = 2'd2,
    OUT_MASSLESS   = 2'd3
  } outcome_t;

  // Control that rides along with each item
  typedef struct packed {
    outcome_t   outcome;
    logic [2:0] neg;
  } ctl_t;

endpackage

// ===== rtl/core/sphere_pair_elastic_collision_unit.sv =====
// Throughput: one item per cycle while no result is stalled; the depth is set
// by the restoring divider, one quotient bit per stage, behind a seven-stage
// geometry pipeline.
// A stalled result holds the whole pipeline in place.
// Reset (rst, synchronous) clears all valid bits and sets contact_mode to 1.
module sphere_pair_elastic_collision_unit import spec_pkg::*; #(
  parameter int COMPONENT_WIDTH = CW_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_a[47:0], vel_a[95:48], pos_b[143:96], vel_b[191:144], radius_a[207:192],
  // radius_b[223:208], mass_a[239:224], mass_b[255:240]
  input  logic [255:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // new_vel_a[47:0], new_vel_b[95:48], outcome[97:96], zero fill[103:98]
  output logic [103:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int CW  = COMPONENT_WIDTH;
  localparam int NW  = 4 * CW + 4;
  localparam int DNW = 3 * CW + 3;
  localparam int QW  = CW + 2;

  logic contact_mode;
  logic en;

  // Register port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      contact_mode <= CONTACT_MODE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CONTACT_MODE) begin
      contact_mode <= pwdata[0];
    end
  end
  assign prdata = (paddr[2] == REG_CONTACT_MODE) ? {31'b0, contact_mode} : 32'b0;

  // Advance everything unless a result waits
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic            f_valid;
  ctl_t            f_ctl;
  logic [3*CW-1:0] f_va, f_vb;
  logic [DNW-1:0]  f_den;
  logic [NW-1:0]   f_numa [3];
  logic [NW-1:0]   f_numb [3];

  spec_front #(.CW(CW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .mode     (contact_mode),
    .pos_a    (s_tdata[47:0]),
    .vel_a    (s_tdata[95:48]),
    .pos_b    (s_tdata[143:96]),
    .vel_b    (s_tdata[191:144]),
    .radius_a (s_tdata[207:192]),
    .radius_b (s_tdata[223:208]),
    .mass_a   (s_tdata[239:224]),
    .mass_b   (s_tdata[255:240]),
    .out_valid(f_valid),
    .out_ctl  (f_ctl),
    .out_va   (f_va),
    .out_vb   (f_vb),
    .out_den  (f_den),
    .out_numa (f_numa),
    .out_numb (f_numb)
  );

  logic [QW-1:0] qa [3];
  logic [QW-1:0] qb [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    spec_divider #(.NW(NW), .DNW(DNW), .QW(QW)) u_div_a (
      .clk(clk), .en(en), .num(f_numa[i]), .den(f_den), .quo(qa[i])
    );
    spec_divider #(.NW(NW), .DNW(DNW), .QW(QW)) u_div_b (
      .clk(clk), .en(en), .num(f_numb[i]), .den(f_den), .quo(qb[i])
    );
  end

  // Carry control and old velocities alongside the divider stages
  logic            dl_v   [QW];
  ctl_t            dl_ctl [QW];
  logic [3*CW-1:0] dl_va  [QW];
  logic [3*CW-1:0] dl_vb  [QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QW; k++) dl_v[k] <= 1'b0;
    end else if (en) begin
      dl_v[0] <= f_valid;
      for (int k = 1; k < QW; k++) dl_v[k] <= dl_v[k-1];
    end
    if (en) begin
      dl_ctl[0] <= f_ctl;
      dl_va[0]  <= f_va;
      dl_vb[0]  <= f_vb;
      for (int k = 1; k < QW; k++) begin
        dl_ctl[k] <= dl_ctl[k-1];
        dl_va[k]  <= dl_va[k-1];
        dl_vb[k]  <= dl_vb[k-1];
      end
    end
  end

  logic [3*CW-1:0] new_a, new_b;
  logic [3*CW+47:0] new_a_x, new_b_x;
  outcome_t        oc;

  spec_update #(.CW(CW)) u_update (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (dl_v[QW-1]),
    .ctl      (dl_ctl[QW-1]),
    .va       (dl_va[QW-1]),
    .vb       (dl_vb[QW-1]),
    .qa       (qa),
    .qb       (qb),
    .out_valid(m_tvalid),
    .new_a    (new_a),
    .new_b    (new_b),
    .outcome  (oc)
  );

  assign new_a_x = {48'b0, new_a};
  assign new_b_x = {48'b0, new_b};
  assign m_tdata = {6'b0, oc, new_b_x[47:0], new_a_x[47:0]};

endmodule

// ===== rtl/core/spec_front.sv =====
// Geometry pipeline: differences, contact test, dot product and numerators
module spec_front import spec_pkg::*; #(
  parameter int CW = CW_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic                  mode,
  input  logic [47:0]           pos_a,
  input  logic [47:0]           vel_a,
  input  logic [47:0]           pos_b,
  input  logic [47:0]           vel_b,
  input  logic [15:0]           radius_a,
  input  logic [15:0]           radius_b,
  input  logic [15:0]           mass_a,
  input  logic [15:0]           mass_b,
  output logic                  out_valid,
  output ctl_t                  out_ctl,
  output logic [3*CW-1:0]       out_va,
  output logic [3*CW-1:0]       out_vb,
  output logic [3*CW+2:0]       out_den,
  output logic [4*CW+3:0]       out_numa [3],
  output logic [4*CW+3:0]       out_numb [3]
);

  localparam int DW  = CW + 1;
  localparam int SQW = 2 * CW + 2;
  localparam int DPW = 2 * CW + 4;
  localparam int TDW = 2 * CW + 3;
  localparam int MW  = CW + 1;
  localparam int DNW = 3 * CW + 3;
  localparam int KW  = 3 * CW + 3;
  localparam int NW  = 4 * CW + 4;

  // Zero-extended inputs so every component select stays in range
  logic [3*CW+47:0] pa_x, va_x, pb_x, vb_x;
  logic [CW+15:0]   ra_x, rb_x, ma_x, mb_x;
  logic signed [DW-1:0] d_c [3];
  logic signed [DW-1:0] dv_c [3];
  logic [CW-1:0] pac, pbc, vac, vbc;

  assign pa_x = {{(3*CW){1'b0}}, pos_a};
  assign va_x = {{(3*CW){1'b0}}, vel_a};
  assign pb_x = {{(3*CW){1'b0}}, pos_b};
  assign vb_x = {{(3*CW){1'b0}}, vel_b};
  assign ra_x = {{CW{1'b0}}, radius_a};
  assign rb_x = {{CW{1'b0}}, radius_b};
  assign ma_x = {{CW{1'b0}}, mass_a};
  assign mb_x = {{CW{1'b0}}, mass_b};

  always_comb begin
    pac = '0; pbc = '0; vac = '0; vbc = '0;
    for (int i = 0; i < 3; i++) begin
      pac = pa_x[i*CW +: CW];
      pbc = pb_x[i*CW +: CW];
      vac = va_x[i*CW +: CW];
      vbc = vb_x[i*CW +: CW];
      d_c[i]  = $signed({pbc[CW-1], pbc}) - $signed({pac[CW-1], pac});
      dv_c[i] = $signed({vbc[CW-1], vbc}) - $signed({vac[CW-1], vac});
    end
  end

  // Stage 1: differences, separation and total mass
  logic                 v1, s1_mode;
  logic signed [DW-1:0] s1_d [3];
  logic signed [DW-1:0] s1_dv [3];
  logic [3*CW-1:0]      s1_va, s1_vb;
  logic [DW-1:0]        s1_sep;
  logic [MW-1:0]        s1_tm;
  logic [CW-1:0]        s1_ma, s1_mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      s1_d    <= d_c;
      s1_dv   <= dv_c;
      s1_va   <= va_x[3*CW-1:0];
      s1_vb   <= vb_x[3*CW-1:0];
      s1_sep  <= {1'b0, ra_x[CW-1:0]} + {1'b0, rb_x[CW-1:0]};
      s1_tm   <= {1'b0, ma_x[CW-1:0]} + {1'b0, mb_x[CW-1:0]};
      s1_ma   <= ma_x[CW-1:0];
      s1_mb   <= mb_x[CW-1:0];
      s1_mode <= mode;
    end
  end

  // Stage 2: squares and the per-axis box test
  logic signed [2*DW-1:0] sq_d [3];
  logic signed [2*DW-1:0] sq_dv [3];
  logic [DW-1:0]          ad1 [3];
  logic                   box_c;

  always_comb begin
    box_c = 1'b1;
    for (int i = 0; i < 3; i++) begin
      sq_d[i]  = s1_d[i] * s1_d[i];
      sq_dv[i] = s1_dv[i] * s1_dv[i];
      ad1[i]   = s1_d[i][DW-1] ? DW'(-s1_d[i]) : DW'(s1_d[i]);
      if (ad1[i] > s1_sep) box_c = 1'b0;
    end
  end

  logic                 v2, s2_mode, s2_box;
  logic [2*CW:0]        s2_dsq [3];
  logic [2*CW:0]        s2_dvsq [3];
  logic [SQW-1:0]       s2_sepsq;
  logic signed [DW-1:0] s2_d [3];
  logic signed [DW-1:0] s2_dv [3];
  logic [3*CW-1:0]      s2_va, s2_vb;
  logic [MW-1:0]        s2_tm;
  logic [CW-1:0]        s2_ma, s2_mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_dsq[i]  <= sq_d[i][2*CW:0];
        s2_dvsq[i] <= sq_dv[i][2*CW:0];
      end
      s2_sepsq <= SQW'(s1_sep * s1_sep);
      s2_box   <= box_c;
      s2_mode  <= s1_mode;
      s2_d     <= s1_d;
      s2_dv    <= s1_dv;
      s2_va    <= s1_va;
      s2_vb    <= s1_vb;
      s2_tm    <= s1_tm;
      s2_ma    <= s1_ma;
      s2_mb    <= s1_mb;
    end
  end

  // Stage 3: distance sums, contact decision, coincident-centre normal
  logic [SQW-1:0]       dsq_c, dvsq_c;
  logic                 contact_c, coinc_c;
  logic signed [DW-1:0] nd_c [3];

  always_comb begin
    dsq_c  = SQW'(s2_dsq[0]) + SQW'(s2_dsq[1]) + SQW'(s2_dsq[2]);
    dvsq_c = SQW'(s2_dvsq[0]) + SQW'(s2_dvsq[1]) + SQW'(s2_dvsq[2]);
    contact_c = (s2_mode == MODE_DISTANCE) ? (dsq_c <= s2_sepsq) : s2_box;
    coinc_c = (dsq_c == '0);
    for (int i = 0; i < 3; i++) begin
      nd_c[i] = coinc_c ? -s2_dv[i] : s2_d[i];
    end
  end

  logic                 v3, s3_contact, s3_tmz;
  logic signed [DW-1:0] s3_nd [3];
  logic signed [DW-1:0] s3_dv [3];
  logic [SQW-1:0]       s3_dsq;
  logic [3*CW-1:0]      s3_va, s3_vb;
  logic [MW-1:0]        s3_tm;
  logic [CW-1:0]        s3_ma, s3_mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      s3_contact <= contact_c;
      s3_tmz     <= (s2_tm == '0);
      s3_nd      <= nd_c;
      s3_dv      <= s2_dv;
      s3_dsq     <= coinc_c ? dvsq_c : dsq_c;
      s3_va      <= s2_va;
      s3_vb      <= s2_vb;
      s3_tm      <= s2_tm;
      s3_ma      <= s2_ma;
      s3_mb      <= s2_mb;
    end
  end

  // Stage 4: dot product terms and the denominator
  logic signed [2*DW-1:0] pr_c [3];
  logic [DW-1:0]          ad3 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr_c[i] = s3_nd[i] * s3_dv[i];
      ad3[i]  = s3_nd[i][DW-1] ? DW'(-s3_nd[i]) : DW'(s3_nd[i]);
    end
  end

  logic                   v4, s4_contact, s4_tmz;
  logic signed [2*DW-1:0] s4_pr [3];
  logic [DW-1:0]          s4_ad [3];
  logic [2:0]             s4_neg;
  logic [DNW-1:0]         s4_den;
  logic [3*CW-1:0]        s4_va, s4_vb;
  logic [CW-1:0]          s4_ma, s4_mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      s4_pr      <= pr_c;
      s4_ad      <= ad3;
      for (int i = 0; i < 3; i++) s4_neg[i] <= s3_nd[i][DW-1];
      s4_den     <= DNW'(s3_dsq * s3_tm);
      s4_contact <= s3_contact;
      s4_tmz     <= s3_tmz;
      s4_va      <= s3_va;
      s4_vb      <= s3_vb;
      s4_ma      <= s3_ma;
      s4_mb      <= s3_mb;
    end
  end

  // Stage 5: dot product sum and outcome
  logic signed [DPW-1:0] dp_c, ndp_c;
  outcome_t              oc_c;

  always_comb begin
    dp_c  = DPW'(s4_pr[0]) + DPW'(s4_pr[1]) + DPW'(s4_pr[2]);
    ndp_c = -dp_c;
    if (!s4_contact)    oc_c = OUT_NONE;
    else if (s4_tmz)    oc_c = OUT_MASSLESS;
    else if (!dp_c[DPW-1]) oc_c = OUT_SEPARATING;
    else                oc_c = OUT_COLLIDED;
  end

  logic            v5;
  ctl_t            s5_ctl;
  logic [TDW-1:0]  s5_tdp;
  logic [DW-1:0]   s5_ad [3];
  logic [DNW-1:0]  s5_den;
  logic [3*CW-1:0] s5_va, s5_vb;
  logic [CW-1:0]   s5_ma, s5_mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      s5_ctl.outcome <= oc_c;
      s5_ctl.neg     <= s4_neg;
      s5_tdp <= {ndp_c[TDW-2:0], 1'b0};
      s5_ad  <= s4_ad;
      s5_den <= s4_den;
      s5_va  <= s4_va;
      s5_vb  <= s4_vb;
      s5_ma  <= s4_ma;
      s5_mb  <= s4_mb;
    end
  end

  // Stage 6: scale the impulse by each mass
  logic            v6;
  ctl_t            s6_ctl;
  logic [KW-1:0]   s6_ka, s6_kb;
  logic [DW-1:0]   s6_ad [3];
  logic [DNW-1:0]  s6_den;
  logic [3*CW-1:0] s6_va, s6_vb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
    if (en) begin
      s6_ka  <= KW'(s5_tdp * s5_mb);
      s6_kb  <= KW'(s5_tdp * s5_ma);
      s6_ctl <= s5_ctl;
      s6_ad  <= s5_ad;
      s6_den <= s5_den;
      s6_va  <= s5_va;
      s6_vb  <= s5_vb;
    end
  end

  // Stage 7: numerators per axis
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v6;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        out_numa[i] <= NW'(s6_ka * s6_ad[i]);
        out_numb[i] <= NW'(s6_kb * s6_ad[i]);
      end
      out_ctl <= s6_ctl;
      out_den <= s6_den;
      out_va  <= s6_va;
      out_vb  <= s6_vb;
    end
  end

endmodule

// ===== rtl/core/spec_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage
module spec_divider import spec_pkg::*; #(
  parameter int NW  = 4 * CW_DEFAULT + 4,
  parameter int DNW = 3 * CW_DEFAULT + 3,
  parameter int QW  = CW_DEFAULT + 2
) (
  input  logic           clk,
  input  logic           en,
  input  logic [NW-1:0]  num,
  input  logic [DNW-1:0] den,
  output logic [QW-1:0]  quo
);

  logic [NW-1:0]  rem_r [QW];
  logic [DNW-1:0] den_r [QW];
  logic [QW-1:0]  quo_r [QW];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    localparam int K = QW - 1 - g;
    logic [NW-1:0]  rem_i, dsh;
    logic [DNW-1:0] den_i;
    logic [QW-1:0]  quo_i;
    logic           ge;

    if (g == 0) begin : g_first
      assign rem_i = num;
      assign den_i = den;
      assign quo_i = '0;
    end else begin : g_rest
      assign rem_i = rem_r[g-1];
      assign den_i = den_r[g-1];
      assign quo_i = quo_r[g-1];
    end

    // Try subtracting the divisor at this bit weight
    assign dsh = {{(NW-DNW){1'b0}}, den_i} << K;
    assign ge  = (rem_i >> K) >= {{(NW-DNW){1'b0}}, den_i};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= ge ? rem_i - dsh : rem_i;
        den_r[g] <= den_i;
        quo_r[g] <= quo_i | (QW'(ge) << K);
      end
    end
  end

  assign quo = quo_r[QW-1];

endmodule

// ===== rtl/core/spec_update.sv =====
// Output stage: apply velocity changes, saturate and hold the result item
module spec_update import spec_pkg::*; #(
  parameter int CW = CW_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  ctl_t            ctl,
  input  logic [3*CW-1:0] va,
  input  logic [3*CW-1:0] vb,
  input  logic [CW+1:0]   qa [3],
  input  logic [CW+1:0]   qb [3],
  output logic            out_valid,
  output logic [3*CW-1:0] new_a,
  output logic [3*CW-1:0] new_b,
  output outcome_t        outcome
);

  localparam int SW = CW + 4;
  localparam logic signed [SW-1:0] SMAX = (SW'(1) <<< (CW - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

  logic signed [SW-1:0] sa, sb, ea, eb, fa, fb;
  logic [CW-1:0]        ca, cb;
  logic [3*CW-1:0]      na_c, nb_c;

  always_comb begin
    na_c = va;
    nb_c = vb;
    sa = '0; sb = '0; ea = '0; eb = '0; fa = '0; fb = '0; ca = '0; cb = '0;
    if (ctl.outcome == OUT_COLLIDED) begin
      for (int i = 0; i < 3; i++) begin
        ca = va[i*CW +: CW];
        cb = vb[i*CW +: CW];
        sa = SW'($signed(ca));
        sb = SW'($signed(cb));
        ea = $signed({2'b00, qa[i]});
        eb = $signed({2'b00, qb[i]});
        if (ctl.neg[i]) begin
          fa = sa + ea;
          fb = sb - eb;
        end else begin
          fa = sa - ea;
          fb = sb + eb;
        end
        // Clamp to the component range
        if (fa > SMAX)      na_c[i*CW +: CW] = SMAX[CW-1:0];
        else if (fa < SMIN) na_c[i*CW +: CW] = SMIN[CW-1:0];
        else                na_c[i*CW +: CW] = fa[CW-1:0];
        if (fb > SMAX)      nb_c[i*CW +: CW] = SMAX[CW-1:0];
        else if (fb < SMIN) nb_c[i*CW +: CW] = SMIN[CW-1:0];
        else                nb_c[i*CW +: CW] = fb[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      new_a   <= na_c;
      new_b   <= nb_c;
      outcome <= ctl.outcome;
    end
  end

endmodule

// ===== rtl/core/spec_checker.sv =====
// Port-level checks of the collision unit, bound to the top level
`include "sphere_pair_elastic_collision_unit_macros.svh"

module spec_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata,
  input logic [31:0]  prdata,
  input logic         pready
);

  // A held result stays offered
  `SPEC_ASSERT_NEXT(a_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid)

  // A held result keeps its data
  `SPEC_ASSERT_NEXT(a_hold_data, clk, rst, m_tvalid && !m_tready, $stable(m_tdata))

  // Input side moves exactly when the output is not stalled
  `SPEC_ASSERT_NOW(a_ready_follows, clk, rst, s_tvalid || !s_tvalid, s_tready == (!m_tvalid || m_tready))

  // Register port never waits and reads back one bit
  `SPEC_ASSERT_NOW(a_apb_read, clk, rst, pready || !pready, pready && prdata[31:1] == 31'b0)

endmodule

bind sphere_pair_elastic_collision_unit spec_checker u_spec_checker (.*);
